@@ sv/tspc_pkg.sv @@
// Package for the terrain splat pixel compositor: sizes, codes, pipeline types
// and the small arithmetic helpers used by the map part's divider and address stages.
// No dependencies.
package tspc_pkg;

  // Field and storage sizes.
  localparam int unsigned LayerCount  = 6;
  localparam int unsigned Channels    = 3;
  localparam int unsigned MaxVertices = 65536;
  localparam int unsigned AddrW       = $clog2(MaxVertices);
  localparam int unsigned VIdxW       = 16;
  localparam int unsigned WeightW     = 8 * LayerCount;
  localparam int unsigned ColorW      = 24;
  localparam int unsigned OutW        = 32;
  localparam int unsigned CellW       = 8;
  localparam int unsigned SizeW       = 13;
  localparam int unsigned PixW        = 12;
  localparam int unsigned FracW       = 16;

  // Position divider: numerator is pixel*(cells+1) with a 16-bit fraction appended.
  localparam int unsigned NumW            = PixW + CellW;
  localparam int unsigned DivW            = NumW + FracW;
  localparam int unsigned DivBitsPerStage = 2;
  localparam int unsigned DivStages       = DivW / DivBitsPerStage;

  // Blend arithmetic. Weights and channels are scaled by 255*2^16.
  localparam int unsigned ScaleW = 24;
  localparam int unsigned LerpW  = ScaleW + FracW + 1;
  localparam int unsigned MulW   = 2 * ScaleW;
  localparam int unsigned YW     = 32;
  localparam int unsigned RecW   = 64;
  localparam logic [ScaleW-1:0] FullScale = ScaleW'(255 * 65536);
  localparam logic [FracW:0]    One16     = {1'b1, {FracW{1'b0}}};
  // Exact unsigned divide by 255 for 32-bit values: (y * Recip255) >> RecipShift.
  localparam logic [YW-1:0]     Recip255  = 32'h8080_8081;
  localparam int unsigned       RecipShift = 39;
  localparam logic [7:0]        OutAlpha  = 8'hFF;

  // Input queue between the front and the back.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  // Grid corners read for one pixel.
  localparam int unsigned Corners  = 4;
  localparam int unsigned Corner00 = 0;  // (x0, z0)
  localparam int unsigned Corner01 = 1;  // (x1, z0)
  localparam int unsigned Corner10 = 2;  // (x0, z1)
  localparam int unsigned Corner11 = 3;  // (x1, z1)

  // Configuration port.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 13;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CELLS_X      = 3'd0,
    REG_CELLS_Z      = 3'd1,
    REG_IMAGE_WIDTH  = 3'd2,
    REG_IMAGE_HEIGHT = 3'd3,
    REG_NORMAL_MODE  = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    OP_WRITE   = 1'b0,
    OP_COMPOSE = 1'b1
  } opcode_e;

  typedef struct packed {
    logic [CellW-1:0] cells_x;
    logic [CellW-1:0] cells_z;
    logic [SizeW-1:0] image_width;
    logic [SizeW-1:0] image_height;
    logic             normal_mode;
  } cfg_t;

  // One queued transaction after decode.
  typedef struct packed {
    logic                               is_compose;
    logic [VIdxW-1:0]                   vertex_index;
    logic [WeightW-1:0]                 vertex_weights;
    logic [NumW-1:0]                    num_x;
    logic [NumW-1:0]                    num_z;
    logic [ColorW-1:0]                  base_color;
    logic [LayerCount-1:0][ColorW-1:0]  layer_color;
  } entry_t;

  // Payload carried along the map pipeline.
  typedef struct packed {
    logic                               is_compose;
    logic [VIdxW-1:0]                   vertex_index;
    logic [WeightW-1:0]                 vertex_weights;
    logic [ColorW-1:0]                  base_color;
    logic [LayerCount-1:0][ColorW-1:0]  layer_color;
  } pl_t;

  // Restoring divider state for one axis.
  typedef struct packed {
    logic [SizeW-1:0] rem;
    logic [DivW-1:0]  num;
    logic [DivW-1:0]  quo;
  } divst_t;

  typedef struct packed {
    pl_t    pl;
    divst_t dx;
    divst_t dz;
  } dv_t;

  typedef struct packed {
    logic [CellW-1:0] lo;
    logic [CellW-1:0] hi;
    logic [FracW-1:0] frac;
  } axis_t;

  // Interpolated weights handed from the map part to the blend part.
  typedef struct packed {
    logic                               is_compose;
    logic [ColorW-1:0]                  base_color;
    logic [LayerCount-1:0][ColorW-1:0]  layer_color;
    logic [LayerCount-1:0][ScaleW-1:0]  w;
  } wt_t;

  // State of one blend stage.
  typedef struct packed {
    logic                               is_compose;
    logic [LayerCount-1:0][ColorW-1:0]  layer_color;
    logic [LayerCount-1:0][ScaleW-1:0]  w;
    logic [Channels-1:0][ScaleW-1:0]    ch;
    logic [Channels-1:0][YW-1:0]        y;
  } bl_t;

  // One quotient bit of a restoring division by d.
  function automatic divst_t div_step(divst_t a, logic [SizeW-1:0] d);
    logic [SizeW:0] t;
    divst_t         r;
    t     = {a.rem, a.num[DivW-1]};
    r.num = {a.num[DivW-2:0], 1'b0};
    if (t >= {1'b0, d}) begin
      r.rem = SizeW'(t - {1'b0, d});
      r.quo = {a.quo[DivW-2:0], 1'b1};
    end else begin
      r.rem = t[SizeW-1:0];
      r.quo = {a.quo[DivW-2:0], 1'b0};
    end
    return r;
  endfunction

  // Cell index with saturation, clamped neighbor and fraction from the quotient.
  function automatic axis_t axis_map(logic [DivW-1:0] q, logic [CellW-1:0] cells);
    logic [NumW-1:0] idx;
    axis_t           r;
    idx    = q[DivW-1:FracW];
    r.lo   = (idx > NumW'(cells)) ? cells : idx[CellW-1:0];
    r.hi   = (r.lo == cells) ? cells : r.lo + CellW'(1);
    r.frac = q[FracW-1:0];
    return r;
  endfunction

endpackage

@@ sv/tspc_if.sv @@
// Valid/ready channel interfaces for the compositor's request and response.
// Depends on tspc_pkg for field widths.
interface tspc_req_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [tspc_pkg::VIdxW-1:0]    vertex_index;
  logic [tspc_pkg::WeightW-1:0]  vertex_weights;
  logic [tspc_pkg::PixW-1:0]     pixel_x;
  logic [tspc_pkg::PixW-1:0]     pixel_z;
  logic [tspc_pkg::ColorW-1:0]   base_color;
  logic [tspc_pkg::ColorW-1:0]   layer_color_0;
  logic [tspc_pkg::ColorW-1:0]   layer_color_1;
  logic [tspc_pkg::ColorW-1:0]   layer_color_2;
  logic [tspc_pkg::ColorW-1:0]   layer_color_3;
  logic [tspc_pkg::ColorW-1:0]   layer_color_4;
  logic [tspc_pkg::ColorW-1:0]   layer_color_5;

  modport source (
    output valid, opcode, vertex_index, vertex_weights, pixel_x, pixel_z, base_color,
           layer_color_0, layer_color_1, layer_color_2, layer_color_3, layer_color_4,
           layer_color_5,
    input  ready
  );
  modport sink (
    input  valid, opcode, vertex_index, vertex_weights, pixel_x, pixel_z, base_color,
           layer_color_0, layer_color_1, layer_color_2, layer_color_3, layer_color_4,
           layer_color_5,
    output ready
  );
endinterface

interface tspc_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [tspc_pkg::OutW-1:0]  out_color;

  modport source (output valid, out_color, input ready);
  modport sink (input valid, out_color, output ready);
endinterface

@@ sv/tspc_ram.sv @@
// Generic single-write, single-read memory with a registered read port.
// No dependencies.
module tspc_ram #(
  parameter int unsigned Depth = 65536,
  parameter int unsigned Width = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/tspc_front.sv @@
// Front part: accepts request transactions, decodes them, forms the scaled
// pixel positions and holds them in a short queue. Depends on tspc_pkg, tspc_if.
module tspc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  tspc_req_if.sink             req_i,
  input  tspc_pkg::cfg_t       cfg_i,
  input  logic                 pop_i,
  output tspc_pkg::entry_t     head_o,
  output logic                 head_valid_o
);

  tspc_pkg::entry_t                 entry;
  tspc_pkg::entry_t                 queue_q [tspc_pkg::QueueDepth];
  logic [tspc_pkg::QPtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [tspc_pkg::QPtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [tspc_pkg::QCntW-1:0]       count_q, count_d;
  logic                             push;

  // Decode the request and scale the position by the vertex count per axis.
  always_comb begin
    entry                = '0;
    entry.is_compose     = (req_i.opcode == tspc_pkg::OP_COMPOSE);
    entry.vertex_index   = req_i.vertex_index;
    entry.vertex_weights = req_i.vertex_weights;
    entry.num_x          = tspc_pkg::NumW'(req_i.pixel_x) *
                           (tspc_pkg::NumW'(cfg_i.cells_x) + tspc_pkg::NumW'(1));
    entry.num_z          = tspc_pkg::NumW'(req_i.pixel_z) *
                           (tspc_pkg::NumW'(cfg_i.cells_z) + tspc_pkg::NumW'(1));
    entry.base_color     = req_i.base_color;
    entry.layer_color[0] = req_i.layer_color_0;
    entry.layer_color[1] = req_i.layer_color_1;
    entry.layer_color[2] = req_i.layer_color_2;
    entry.layer_color[3] = req_i.layer_color_3;
    entry.layer_color[4] = req_i.layer_color_4;
    entry.layer_color[5] = req_i.layer_color_5;
  end

  assign req_i.ready  = (count_q != tspc_pkg::QCntW'(tspc_pkg::QueueDepth));
  assign push         = req_i.valid & req_i.ready;
  assign head_valid_o = (count_q != '0);
  assign head_o       = queue_q[rd_ptr_q];

  // Queue pointers and fill count.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + tspc_pkg::QPtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + tspc_pkg::QPtrW'(1);
    end
    if (push && !pop_i) begin
      count_d = count_q + tspc_pkg::QCntW'(1);
    end else if (!push && pop_i) begin
      count_d = count_q - tspc_pkg::QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= entry;
    end
  end

endmodule

@@ sv/tspc_map.sv @@
// Map part of the back end: divides the positions into cell index and fraction,
// forms the four corner addresses, updates and reads the weight grid and
// interpolates the six weights. Depends on tspc_pkg and tspc_ram.
module tspc_map (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tspc_pkg::cfg_t       cfg_i,
  input  logic                 advance_i,
  input  tspc_pkg::entry_t     head_i,
  input  logic                 head_valid_i,
  output logic                 pop_o,
  output logic                 wt_valid_o,
  output tspc_pkg::wt_t        wt_o
);

  localparam int unsigned Last = tspc_pkg::DivStages - 1;

  logic [tspc_pkg::SizeW-1:0]  size_x, size_z;
  tspc_pkg::dv_t               init;
  tspc_pkg::dv_t               dv_q [tspc_pkg::DivStages];
  logic                        dv_valid_q [tspc_pkg::DivStages];

  // Address stage.
  tspc_pkg::axis_t             ax, az;
  logic [tspc_pkg::CellW:0]    stride;
  logic [tspc_pkg::Corners-1:0][tspc_pkg::AddrW-1:0] addr_d, addr_q;
  tspc_pkg::pl_t               a_pl_q;
  logic [tspc_pkg::FracW-1:0]  a_fx_q, a_fz_q;
  logic                        a_valid_q;

  // Memory stage.
  tspc_pkg::pl_t               m_pl_q;
  logic [tspc_pkg::FracW-1:0]  m_fx_q, m_fz_q;
  logic                        m_valid_q;
  logic [tspc_pkg::Corners-1:0][tspc_pkg::WeightW-1:0] rd;
  logic                        ram_we;

  // Horizontal interpolation stage.
  logic [tspc_pkg::LayerCount-1:0][tspc_pkg::ScaleW-1:0] top_d, bot_d, top_q, bot_q;
  tspc_pkg::pl_t               h_pl_q;
  logic [tspc_pkg::FracW-1:0]  h_fz_q;
  logic                        h_valid_q;

  // Vertical interpolation stage.
  tspc_pkg::wt_t               wt_d, wt_q;
  logic                        wt_valid_q;

  // A zero image size acts as one.
  assign size_x = (cfg_i.image_width  == '0) ? tspc_pkg::SizeW'(1) : cfg_i.image_width;
  assign size_z = (cfg_i.image_height == '0) ? tspc_pkg::SizeW'(1) : cfg_i.image_height;

  assign pop_o = advance_i & head_valid_i;

  // Divider input: scaled position with the fraction bits appended.
  always_comb begin
    init                   = '0;
    init.pl.is_compose     = head_i.is_compose;
    init.pl.vertex_index   = head_i.vertex_index;
    init.pl.vertex_weights = head_i.vertex_weights;
    init.pl.base_color     = head_i.base_color;
    init.pl.layer_color    = head_i.layer_color;
    init.dx.num            = {head_i.num_x, tspc_pkg::FracW'(0)};
    init.dz.num            = {head_i.num_z, tspc_pkg::FracW'(0)};
  end

  // Pipelined restoring dividers, two quotient bits per stage on each axis.
  for (genvar g = 0; g < tspc_pkg::DivStages; g++) begin : g_div
    tspc_pkg::dv_t prev;
    tspc_pkg::dv_t nxt;
    logic          prev_v;

    if (g == 0) begin : g_first
      assign prev   = init;
      assign prev_v = head_valid_i;
    end else begin : g_next
      assign prev   = dv_q[g-1];
      assign prev_v = dv_valid_q[g-1];
    end

    always_comb begin
      nxt = prev;
      for (int b = 0; b < tspc_pkg::DivBitsPerStage; b++) begin
        nxt.dx = tspc_pkg::div_step(nxt.dx, size_x);
        nxt.dz = tspc_pkg::div_step(nxt.dz, size_z);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_valid_q[g] <= 1'b0;
      end else if (advance_i) begin
        dv_valid_q[g] <= prev_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (advance_i) begin
        dv_q[g] <= nxt;
      end
    end
  end

  // Cell indices, clamped neighbors and row-major corner addresses.
  always_comb begin
    ax     = tspc_pkg::axis_map(dv_q[Last].dx.quo, cfg_i.cells_x);
    az     = tspc_pkg::axis_map(dv_q[Last].dz.quo, cfg_i.cells_z);
    stride = (tspc_pkg::CellW + 1)'(cfg_i.cells_x) + (tspc_pkg::CellW + 1)'(1);
    addr_d[tspc_pkg::Corner00] = tspc_pkg::AddrW'(az.lo) * tspc_pkg::AddrW'(stride) +
                                 tspc_pkg::AddrW'(ax.lo);
    addr_d[tspc_pkg::Corner01] = tspc_pkg::AddrW'(az.lo) * tspc_pkg::AddrW'(stride) +
                                 tspc_pkg::AddrW'(ax.hi);
    addr_d[tspc_pkg::Corner10] = tspc_pkg::AddrW'(az.hi) * tspc_pkg::AddrW'(stride) +
                                 tspc_pkg::AddrW'(ax.lo);
    addr_d[tspc_pkg::Corner11] = tspc_pkg::AddrW'(az.hi) * tspc_pkg::AddrW'(stride) +
                                 tspc_pkg::AddrW'(ax.hi);
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      a_pl_q <= dv_q[Last].pl;
      a_fx_q <= ax.frac;
      a_fz_q <= az.frac;
      addr_q <= addr_d;
    end
  end

  // Grid writes and reads happen in transaction order at this stage, so a
  // compose behind a write sees the new weights.
  assign ram_we = advance_i & a_valid_q & ~a_pl_q.is_compose;

  for (genvar c = 0; c < tspc_pkg::Corners; c++) begin : g_ram
    tspc_ram #(
      .Depth (tspc_pkg::MaxVertices),
      .Width (tspc_pkg::WeightW)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (ram_we),
      .waddr_i (tspc_pkg::AddrW'(a_pl_q.vertex_index)),
      .wdata_i (a_pl_q.vertex_weights),
      .re_i    (advance_i),
      .raddr_i (addr_q[c]),
      .rdata_o (rd[c])
    );
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      m_pl_q <= a_pl_q;
      m_fx_q <= a_fx_q;
      m_fz_q <= a_fz_q;
    end
  end

  // Horizontal interpolation of each layer weight on both rows.
  always_comb begin
    logic [tspc_pkg::FracW:0] omfx;
    omfx = tspc_pkg::One16 - (tspc_pkg::FracW + 1)'(m_fx_q);
    for (int k = 0; k < tspc_pkg::LayerCount; k++) begin
      top_d[k] = tspc_pkg::ScaleW'(rd[tspc_pkg::Corner00][8*k +: 8]) * tspc_pkg::ScaleW'(omfx) +
                 tspc_pkg::ScaleW'(rd[tspc_pkg::Corner01][8*k +: 8]) * tspc_pkg::ScaleW'(m_fx_q);
      bot_d[k] = tspc_pkg::ScaleW'(rd[tspc_pkg::Corner10][8*k +: 8]) * tspc_pkg::ScaleW'(omfx) +
                 tspc_pkg::ScaleW'(rd[tspc_pkg::Corner11][8*k +: 8]) * tspc_pkg::ScaleW'(m_fx_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      h_pl_q <= m_pl_q;
      h_fz_q <= m_fz_q;
      top_q  <= top_d;
      bot_q  <= bot_d;
    end
  end

  // Vertical interpolation, truncated to units of 1/(255*2^16).
  always_comb begin
    logic [tspc_pkg::FracW:0]  omfz;
    logic [tspc_pkg::LerpW-1:0] sum;
    logic [tspc_pkg::ScaleW-1:0] w;
    omfz             = tspc_pkg::One16 - (tspc_pkg::FracW + 1)'(h_fz_q);
    sum              = '0;
    w                = '0;
    wt_d             = '0;
    wt_d.is_compose  = h_pl_q.is_compose;
    wt_d.base_color  = h_pl_q.base_color;
    wt_d.layer_color = h_pl_q.layer_color;
    for (int k = 0; k < tspc_pkg::LayerCount; k++) begin
      sum = tspc_pkg::LerpW'(top_q[k]) * tspc_pkg::LerpW'(omfz) +
            tspc_pkg::LerpW'(bot_q[k]) * tspc_pkg::LerpW'(h_fz_q);
      w   = sum[tspc_pkg::FracW +: tspc_pkg::ScaleW];
      wt_d.w[k] = (w > tspc_pkg::FullScale) ? tspc_pkg::FullScale : w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      wt_q <= wt_d;
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q  <= 1'b0;
      m_valid_q  <= 1'b0;
      h_valid_q  <= 1'b0;
      wt_valid_q <= 1'b0;
    end else if (advance_i) begin
      a_valid_q  <= dv_valid_q[Last];
      m_valid_q  <= a_valid_q;
      h_valid_q  <= m_valid_q;
      wt_valid_q <= h_valid_q;
    end
  end

  assign wt_valid_o = wt_valid_q;
  assign wt_o       = wt_q;

endmodule

@@ sv/tspc_blend.sv @@
// Blend part of the back end: blends the six layers into the base color one
// layer per two stages, packs the pixel and holds it in the output register.
// Depends on tspc_pkg and tspc_if.
module tspc_blend (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tspc_pkg::cfg_t       cfg_i,
  input  logic                 wt_valid_i,
  input  tspc_pkg::wt_t        wt_i,
  tspc_rsp_if.source           rsp_o,
  output logic                 advance_o
);

  localparam int unsigned Last = tspc_pkg::LayerCount - 1;

  tspc_pkg::bl_t             p_q [tspc_pkg::LayerCount];
  logic                      p_valid_q [tspc_pkg::LayerCount];
  tspc_pkg::bl_t             q_q [tspc_pkg::LayerCount];
  logic                      q_valid_q [tspc_pkg::LayerCount];

  logic                      advance;
  logic                      out_valid_q;
  logic [tspc_pkg::OutW-1:0] out_color_q, out_color_d;

  // The whole back end holds while a finished pixel waits at the output.
  assign advance   = ~(out_valid_q & ~rsp_o.ready);
  assign advance_o = advance;

  for (genvar k = 0; k < tspc_pkg::LayerCount; k++) begin : g_layer
    tspc_pkg::bl_t pin;
    logic          pin_v;
    tspc_pkg::bl_t pn;
    tspc_pkg::bl_t qn;

    // Stage input: the base color scaled by 2^16 for the first layer.
    if (k == 0) begin : g_first
      always_comb begin
        pin             = '0;
        pin.is_compose  = wt_i.is_compose;
        pin.layer_color = wt_i.layer_color;
        pin.w           = wt_i.w;
        for (int c = 0; c < tspc_pkg::Channels; c++) begin
          pin.ch[c] = {wt_i.base_color[8*c +: 8], tspc_pkg::FracW'(0)};
        end
      end
      assign pin_v = wt_valid_i;
    end else begin : g_next
      assign pin   = q_q[k-1];
      assign pin_v = q_valid_q[k-1];
    end

    // Numerator of the blend, already divided by 2^16.
    always_comb begin
      logic [tspc_pkg::MulW-1:0] prod;
      logic [tspc_pkg::ScaleW-1:0] omw;
      pn   = pin;
      omw  = tspc_pkg::FullScale - pin.w[k];
      prod = '0;
      for (int c = 0; c < tspc_pkg::Channels; c++) begin
        prod     = tspc_pkg::MulW'(pin.ch[c]) * tspc_pkg::MulW'(omw);
        pn.y[c]  = prod[tspc_pkg::FracW +: tspc_pkg::YW] +
                   tspc_pkg::YW'(pin.layer_color[k][8*c +: 8]) * tspc_pkg::YW'(pin.w[k]);
      end
    end

    // Divide by 255 through the reciprocal.
    always_comb begin
      logic [tspc_pkg::RecW-1:0] rec;
      qn  = p_q[k];
      rec = '0;
      for (int c = 0; c < tspc_pkg::Channels; c++) begin
        rec      = tspc_pkg::RecW'(p_q[k].y[c]) * tspc_pkg::RecW'(tspc_pkg::Recip255);
        qn.ch[c] = rec[tspc_pkg::RecipShift +: tspc_pkg::ScaleW];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        p_valid_q[k] <= 1'b0;
        q_valid_q[k] <= 1'b0;
      end else if (advance) begin
        p_valid_q[k] <= pin_v;
        q_valid_q[k] <= p_valid_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (advance) begin
        p_q[k] <= pn;
        q_q[k] <= qn;
      end
    end
  end

  // Final channel scaling and packing with opaque alpha.
  always_comb begin
    logic [tspc_pkg::ScaleW:0] biased;
    logic [7:0]                v;
    biased      = '0;
    v           = '0;
    out_color_d = {tspc_pkg::OutAlpha, 24'h0};
    for (int c = 0; c < tspc_pkg::Channels; c++) begin
      if (cfg_i.normal_mode) begin
        biased = (tspc_pkg::ScaleW + 1)'(q_q[Last].ch[c]) +
                 (tspc_pkg::ScaleW + 1)'(tspc_pkg::FullScale);
        v      = biased[tspc_pkg::FracW+1 +: 8];
      end else begin
        v      = q_q[Last].ch[c][tspc_pkg::FracW +: 8];
      end
      out_color_d[8*c +: 8] = v;
    end
  end

  // Output register; weight writes leave no pixel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= q_valid_q[Last] & q_q[Last].is_compose;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_color_q <= out_color_d;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.out_color = out_color_q;

endmodule

@@ sv/terrain_splat_pixel_compose_top.sv @@
// Top level of the terrain splat pixel compositor: configuration registers,
// front queue, map and blend back end. Depends on tspc_pkg, tspc_if,
// tspc_front, tspc_map and tspc_blend.
//
//   channel   direction  handshake          payload
//   req_i     in         valid/ready        opcode, vertex fields, pixel, colors
//   rsp_o     out        valid/ready        out_color
//   cfg       in         cfg_we_i only      cfg_idx_i, cfg_data_i
//
// One transaction per cycle is accepted and one pixel per cycle delivered
// while the output is not stalled. A compose passes through the two-bit-per-stage
// position divider stages, the first fed straight from the queue head, then the
// address, grid read, horizontal and vertical interpolation stages, the product and
// divide-by-255 registers of the six layer blends and the output register. A weight
// write updates the grid from the address stage, in order with the composes around
// it. The grid is not cleared at reset. A pixel held at the output freezes the
// back end; the four-entry queue keeps taking transactions until it fills.
module terrain_splat_pixel_compose_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  tspc_req_if.sink                        req_i,
  tspc_rsp_if.source                      rsp_o,
  input  logic                            cfg_we_i,
  input  logic [tspc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [tspc_pkg::CfgDataW-1:0]   cfg_data_i
);

  tspc_pkg::cfg_t    cfg_q, cfg_d;
  tspc_pkg::entry_t  head;
  logic              head_valid;
  logic              pop;
  logic              advance;
  logic              wt_valid;
  tspc_pkg::wt_t     wt;

  // Configuration register writes.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (tspc_pkg::cfg_reg_e'(cfg_idx_i))
        tspc_pkg::REG_CELLS_X:      cfg_d.cells_x      = cfg_data_i[tspc_pkg::CellW-1:0];
        tspc_pkg::REG_CELLS_Z:      cfg_d.cells_z      = cfg_data_i[tspc_pkg::CellW-1:0];
        tspc_pkg::REG_IMAGE_WIDTH:  cfg_d.image_width  = cfg_data_i[tspc_pkg::SizeW-1:0];
        tspc_pkg::REG_IMAGE_HEIGHT: cfg_d.image_height = cfg_data_i[tspc_pkg::SizeW-1:0];
        tspc_pkg::REG_NORMAL_MODE:  cfg_d.normal_mode  = cfg_data_i[0];
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cells_x      <= tspc_pkg::CellW'(1);
      cfg_q.cells_z      <= tspc_pkg::CellW'(1);
      cfg_q.image_width  <= tspc_pkg::SizeW'(1024);
      cfg_q.image_height <= tspc_pkg::SizeW'(1024);
      cfg_q.normal_mode  <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tspc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .cfg_i        (cfg_q),
    .pop_i        (pop),
    .head_o       (head),
    .head_valid_o (head_valid)
  );

  tspc_map u_map (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .advance_i    (advance),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .wt_valid_o   (wt_valid),
    .wt_o         (wt)
  );

  tspc_blend u_blend (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .wt_valid_i (wt_valid),
    .wt_i       (wt),
    .rsp_o      (rsp_o),
    .advance_o  (advance)
  );

  // The back end must freeze while a result waits at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.ready) |-> !advance)
    else $error("back end advanced while the output was stalled");

  // The queue is only drained when it holds a transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid)
    else $error("queue popped while empty");

  // A delivered pixel always carries opaque alpha.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.out_color[31:24] == tspc_pkg::OutAlpha))
    else $error("output alpha is not opaque");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the terrain splat pixel compositor.
// Depends on tspc_pkg, tspc_if and terrain_splat_pixel_compose_top.
module testbench;
  import tspc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Index outside the register map, written once to show it has no effect.
  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;
  localparam int unsigned DrainCycles = 60;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned HoldCycles  = 300;
  localparam longint unsigned FullW   = 64'd255 * 64'd65536;

  typedef struct packed {
    opcode_e                           op;
    logic [VIdxW-1:0]                  vidx;
    logic [WeightW-1:0]                wts;
    logic [PixW-1:0]                   px;
    logic [PixW-1:0]                   pz;
    logic [ColorW-1:0]                 base;
    logic [LayerCount-1:0][ColorW-1:0] layer;
  } splat_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  tspc_req_if req_if ();
  tspc_rsp_if rsp_if ();

  terrain_splat_pixel_compose_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // Shadow copy of the configuration and the weight grid.
  int unsigned sh_cells_x = 1, sh_cells_z = 1, sh_width = 1024, sh_height = 1024;
  bit sh_normal = 1'b0;
  logic [WeightW-1:0] weight_mem [MaxVertices];
  bit vertex_written [MaxVertices];

  splat_item_t pending_items[$];
  logic [OutW-1:0] expected_colors[$];
  splat_item_t cur_item;
  bit req_busy = 1'b0, req_taken = 1'b0, quiet = 1'b0;
  int unsigned req_gap = 0, rsp_stall = 0, rsp_hold = 0, pixels_seen = 0;
  bit hold_done = 1'b0;
  int unsigned err_count = 0, cycle_count = 0;

  // Maps one pixel coordinate onto the grid: low vertex, clamped neighbor, fraction.
  function automatic void grid_axis(input int unsigned p, input int unsigned cells,
                                    input int unsigned size, output int unsigned lo,
                                    output int unsigned hi, output longint unsigned frac);
    int unsigned s, num, idx;
    s    = (size == 0) ? 1 : size;
    num  = p * (cells + 1);
    idx  = num / s;
    frac = (longint'(num % s) << 16) / s;
    if (idx > cells) idx = cells;
    lo = idx;
    hi = (idx + 1 > cells) ? cells : idx + 1;
  endfunction

  // Row-major indices of the four corners that a compose reads.
  function automatic void pixel_corners(input splat_item_t it, output int unsigned c[4]);
    int unsigned x0, x1, z0, z1;
    longint unsigned fx, fz;
    grid_axis(it.px, sh_cells_x, sh_width, x0, x1, fx);
    grid_axis(it.pz, sh_cells_z, sh_height, z0, z1, fz);
    c[0] = x0 + z0 * (sh_cells_x + 1);
    c[1] = x1 + z0 * (sh_cells_x + 1);
    c[2] = x0 + z1 * (sh_cells_x + 1);
    c[3] = x1 + z1 * (sh_cells_x + 1);
  endfunction

  // Bilinear weight interpolation and layer blend of one pixel.
  function automatic logic [OutW-1:0] blend_pixel(input splat_item_t it);
    int unsigned c[4];
    int unsigned x0, x1, z0, z1;
    longint unsigned fx, fz, top, bot, w, l, v;
    longint unsigned ch[3];
    logic [WeightW-1:0] v00, v01, v10, v11;
    logic [OutW-1:0] res;
    grid_axis(it.px, sh_cells_x, sh_width, x0, x1, fx);
    grid_axis(it.pz, sh_cells_z, sh_height, z0, z1, fz);
    pixel_corners(it, c);
    v00 = weight_mem[c[0]];
    v01 = weight_mem[c[1]];
    v10 = weight_mem[c[2]];
    v11 = weight_mem[c[3]];
    for (int k = 0; k < 3; k++) ch[k] = longint'(it.base[8*k +: 8]) << 16;
    for (int j = 0; j < LayerCount; j++) begin
      top = v00[8*j +: 8] * (65536 - fx) + v01[8*j +: 8] * fx;
      bot = v10[8*j +: 8] * (65536 - fx) + v11[8*j +: 8] * fx;
      w = (top * (65536 - fz) + bot * fz) >> 16;
      if (w > FullW) w = FullW;
      for (int k = 0; k < 3; k++) begin
        l = longint'(it.layer[j][8*k +: 8]) << 16;
        ch[k] = (ch[k] * (FullW - w) + l * w) / FullW;
      end
    end
    res = {OutAlpha, 24'h0};
    for (int k = 0; k < 3; k++) begin
      v = sh_normal ? ((ch[k] + FullW) >> 17) : (ch[k] >> 16);
      if (v > 255) v = 255;
      res[8*k +: 8] = v[7:0];
    end
    return res;
  endfunction

  function automatic logic [WeightW-1:0] rand_weights();
    logic [WeightW-1:0] r;
    for (int j = 0; j < LayerCount; j++) begin
      case ($urandom_range(0, 3))
        0: r[8*j +: 8] = 8'h00;
        1: r[8*j +: 8] = 8'hFF;
        default: r[8*j +: 8] = 8'($urandom_range(0, 255));
      endcase
    end
    return r;
  endfunction

  function automatic logic [ColorW-1:0] rand_color();
    case ($urandom_range(0, 5))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      default: return ColorW'($urandom_range(0, 24'hFFFFFF));
    endcase
  endfunction

  task automatic queue_write(input int unsigned idx, input logic [WeightW-1:0] wts);
    splat_item_t it;
    it      = '0;
    it.op   = OP_WRITE;
    it.vidx = VIdxW'(idx);
    it.wts  = wts;
    it.px   = PixW'($urandom);
    it.pz   = PixW'($urandom);
    it.base = ColorW'($urandom);
    for (int j = 0; j < LayerCount; j++) it.layer[j] = ColorW'($urandom);
    vertex_written[idx] = 1'b1;
    pending_items.push_back(it);
  endtask

  // Queues a compose, preceded by weight writes for any corner not yet written.
  task automatic queue_compose(input int unsigned px, input int unsigned pz,
                               input bit colors_random);
    splat_item_t it;
    int unsigned c[4];
    it      = '0;
    it.op   = OP_COMPOSE;
    it.vidx = VIdxW'($urandom);
    it.wts  = WeightW'({$urandom, $urandom});
    it.px   = PixW'(px);
    it.pz   = PixW'(pz);
    it.base = colors_random ? rand_color() : 24'h000000;
    for (int j = 0; j < LayerCount; j++)
      it.layer[j] = colors_random ? rand_color() : 24'hFFFFFF;
    pixel_corners(it, c);
    for (int i = 0; i < 4; i++)
      if (!vertex_written[c[i]]) queue_write(c[i], rand_weights());
    pending_items.push_back(it);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    case (idx)
      REG_CELLS_X:      sh_cells_x = 32'(data[CellW-1:0]);
      REG_CELLS_Z:      sh_cells_z = 32'(data[CellW-1:0]);
      REG_IMAGE_WIDTH:  sh_width   = 32'(data);
      REG_IMAGE_HEIGHT: sh_height  = 32'(data);
      REG_NORMAL_MODE:  sh_normal  = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Upper data bits beyond a register's width are filled with noise.
  task automatic setup_grid(input int unsigned cx, input int unsigned cz,
                            input int unsigned w, input int unsigned h, input bit nm);
    write_reg(REG_CELLS_X, {5'($urandom), 8'(cx)});
    write_reg(REG_CELLS_Z, {5'($urandom), 8'(cz)});
    write_reg(REG_IMAGE_WIDTH, 13'(w));
    write_reg(REG_IMAGE_HEIGHT, 13'(h));
    write_reg(REG_NORMAL_MODE, {12'($urandom), nm});
  endtask

  // Random mix: mostly composes on the grid, some writes anywhere in the store.
  task automatic queue_random(input int unsigned n);
    int unsigned cells;
    for (int i = 0; i < n; i++) begin
      cells = (sh_cells_x + 1) * (sh_cells_z + 1);
      case ($urandom_range(0, 9))
        0: queue_write($urandom_range(0, MaxVertices - 1), rand_weights());
        1, 2: queue_write($urandom_range(0, cells - 1), rand_weights());
        3: queue_compose($urandom_range(0, 4095), $urandom_range(0, 4095), 1'b1);
        default: queue_compose($urandom_range(0, (sh_width > 0 ? sh_width : 1) - 1) % 4096,
                               $urandom_range(0, (sh_height > 0 ? sh_height : 1) - 1) % 4096,
                               1'b1);
      endcase
    end
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || req_busy || expected_colors.size() != 0)
      @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Request driver: presents queued transactions with random gaps between them.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (req_taken) begin
        req_taken = 1'b0;
        req_busy  = 1'b0;
        if (!quiet && $urandom_range(0, 3) == 0) req_gap = $urandom_range(1, 11);
      end
      if (!req_busy) begin
        if (req_gap > 0) begin
          req_gap--;
        end else if (pending_items.size() != 0) begin
          cur_item = pending_items.pop_front();
          req_busy = 1'b1;
          req_if.opcode         = cur_item.op;
          req_if.vertex_index   = cur_item.vidx;
          req_if.vertex_weights = cur_item.wts;
          req_if.pixel_x        = cur_item.px;
          req_if.pixel_z        = cur_item.pz;
          req_if.base_color     = cur_item.base;
          req_if.layer_color_0  = cur_item.layer[0];
          req_if.layer_color_1  = cur_item.layer[1];
          req_if.layer_color_2  = cur_item.layer[2];
          req_if.layer_color_3  = cur_item.layer[3];
          req_if.layer_color_4  = cur_item.layer[4];
          req_if.layer_color_5  = cur_item.layer[5];
        end
      end
      req_if.valid = req_busy;
    end
  end

  // Response ready: random stall bursts and one long hold-off to fill the block.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && pixels_seen >= 20) begin
        hold_done = 1'b1;
        rsp_hold  = HoldCycles;
      end
      if (rsp_hold > 0) begin
        rsp_hold--;
        rsp_if.ready = 1'b0;
      end else if (rsp_stall > 0) begin
        rsp_stall--;
        rsp_if.ready = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        rsp_stall = $urandom_range(0, 10);
        rsp_if.ready = 1'b0;
      end else begin
        rsp_if.ready = 1'b1;
      end
    end
  end

  // Monitor: predicts accepted transactions and checks each delivered pixel.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("testbench failed");
      $finish;
    end else if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        req_taken = 1'b1;
        if (cur_item.op == OP_WRITE) weight_mem[cur_item.vidx] = cur_item.wts;
        else expected_colors.push_back(blend_pixel(cur_item));
      end
      if (rsp_if.valid && rsp_if.ready) begin
        pixels_seen++;
        if (expected_colors.size() == 0) begin
          $error("out_color: no pixel expected, actual %h", rsp_if.out_color);
          err_count++;
        end else if (rsp_if.out_color !== expected_colors[0]) begin
          $error("out_color: expected %h, actual %h", expected_colors[0], rsp_if.out_color);
          err_count++;
          void'(expected_colors.pop_front());
        end else begin
          void'(expected_colors.pop_front());
        end
      end
    end
  end

  // Stimulus phases: reset settings, then the grid and image extremes, then random.
  initial begin
    req_if.valid = 1'b0;
    req_if.opcode = OP_WRITE;
    req_if.vertex_index = '0;
    req_if.vertex_weights = '0;
    req_if.pixel_x = '0;
    req_if.pixel_z = '0;
    req_if.base_color = '0;
    req_if.layer_color_0 = '0;
    req_if.layer_color_1 = '0;
    req_if.layer_color_2 = '0;
    req_if.layer_color_3 = '0;
    req_if.layer_color_4 = '0;
    req_if.layer_color_5 = '0;
    rsp_if.ready = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: 2x2 vertices with extreme weights, corners and beyond-image pixels.
    queue_write(0, '0);
    queue_write(1, '1);
    queue_write(2, 48'hFF00FF00FF00);
    queue_write(3, 48'h00FF00FF00FF);
    queue_compose(0, 0, 1'b0);
    queue_compose(1023, 0, 1'b0);
    queue_compose(0, 1023, 1'b0);
    queue_compose(512, 512, 1'b0);
    queue_compose(4095, 4095, 1'b1);
    queue_compose(1500, 100, 1'b1);
    queue_random(40);
    wait_drained();

    // Single vertex, zero width, normal mode, and a write to an unmapped register.
    setup_grid(0, 0, 0, 1, 1'b1);
    write_reg(RegUnused, 13'h1FFF);
    queue_compose(0, 0, 1'b0);
    queue_compose(4095, 4095, 1'b1);
    queue_random(40);
    wait_drained();

    // Largest grid and image.
    setup_grid(255, 255, 4096, 4096, 1'b0);
    queue_compose(4095, 4095, 1'b1);
    queue_compose(0, 4095, 1'b1);
    queue_random(20);
    wait_drained();

    setup_grid(255, 3, 1, 4095, 1'b1);
    queue_random(30);
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      setup_grid($urandom_range(1, 20), $urandom_range(1, 20), $urandom_range(1, 4096),
                 $urandom_range(1, 4096), $urandom_range(0, 1));
      if (ph == 2) quiet = 1'b1;
      queue_random(25);
      wait_drained();
    end

    if (err_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
